// File: sv/tlbp_pkg.sv
// shared types, constants and codes of the two-level token bucket policer
package tlbp_pkg;

  localparam int unsigned NETWORKS   = 16;
  localparam int unsigned PEER_SLOTS = 256;

  localparam int unsigned NET_AW  = (NETWORKS > 1) ? $clog2(NETWORKS) : 1;
  localparam int unsigned PEER_AW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned SLOT_AW = (NET_AW > PEER_AW) ? NET_AW : PEER_AW;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned NIDX_W  = 4;
  localparam int unsigned PIDX_W  = 8;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned RATE_W  = 40;
  localparam int unsigned BURST_W = 48;
  localparam int unsigned MULT_W  = 8;
  localparam int unsigned OUTC_W  = 3;
  localparam int unsigned DROP_W  = 32;

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 4;

  localparam logic [MULT_W-1:0] MULT_RESET = 8'd2;

  // refill datapath
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned MUL_STEPS  = 3;
  localparam int unsigned ACC_W      = RATE_W + TIME_W;
  localparam int unsigned SAT_BIT    = 58;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_W      = 60;
  localparam int unsigned DIV_STEPS  = DIV_W / DIV_BITS;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned QUO_W      = 49;

  typedef enum logic [KIND_W-1:0] {
    KIND_PACKET   = 2'd0,
    KIND_SET_NET  = 2'd1,
    KIND_SET_PEER = 2'd2,
    KIND_SWEEP    = 2'd3
  } kind_e;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_PASS     = 3'd0,
    OUTC_NET_DROP = 3'd1,
    OUTC_PEER_DROP = 3'd2,
    OUTC_SET_OK   = 3'd3,
    OUTC_SET_REJ  = 3'd4,
    OUTC_SWEPT    = 3'd5
  } outcome_e;

  typedef struct packed {
    logic [NIDX_W-1:0]  tag;
    logic [DROP_W-1:0]  drops;
    logic [TIME_W-1:0]  last_ms;
    logic [BURST_W-1:0] tokens;
    logic [BURST_W-1:0] burst;
    logic [RATE_W-1:0]  rate;
  } bucket_t;

  localparam int unsigned BUCKET_W = $bits(bucket_t);

endpackage

// File: sv/tlbp_ram.sv
// generic single-port-write, registered-read ram
module tlbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/tlbp_refill.sv
// lazy refill unit: min(burst, tokens + rate * elapsed / 1000)
module tlbp_refill (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tlbp_pkg::RATE_W-1:0]    rate_i,
  input  logic [tlbp_pkg::BURST_W-1:0]   burst_i,
  input  logic [tlbp_pkg::BURST_W-1:0]   tokens_i,
  input  logic [tlbp_pkg::TIME_W-1:0]    last_i,
  input  logic [tlbp_pkg::TIME_W-1:0]    now_i,
  output logic                           done_o,
  output logic [tlbp_pkg::BURST_W-1:0]   tokens_o
);
  import tlbp_pkg::*;

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_MUL  = 4'b0010,
    R_DIV  = 4'b0100,
    R_FIN  = 4'b1000
  } rstate_e;

  rstate_e             state_q, state_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [BURST_W-1:0]  burst_q, burst_d;
  logic [BURST_W-1:0]  tok_q, tok_d;
  logic [TIME_W-1:0]   dt_q, dt_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [DIV_W-1:0]    p_q, p_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic                sat_q, sat_d;
  logic                done_q, done_d;
  logic [BURST_W-1:0]  out_q, out_d;

  logic [CHUNK_W-1:0]          chunk;
  logic [RATE_W+CHUNK_W-1:0]   pp;
  logic [ACC_W-1:0]            acc_sum;
  logic [DIV_W-1:0]            p_step;
  logic [REM_W-1:0]            rem_step;
  logic [QUO_W:0]              fin_sum;

  assign chunk   = dt_q[cnt_q[1:0]*CHUNK_W +: CHUNK_W];
  assign pp      = rate_q * chunk;
  assign acc_sum = acc_q + (ACC_W'(pp) << (cnt_q[1:0]*CHUNK_W));
  assign fin_sum = (QUO_W+1)'(tok_q) + (QUO_W+1)'(p_q[QUO_W-1:0]);

  // four restoring steps of the divide by 1000
  always_comb begin
    logic [REM_W:0]   r;
    logic [DIV_W-1:0] pv;
    logic [REM_W-1:0] rv;
    pv = p_q;
    rv = rem_q;
    for (int j = 0; j < DIV_BITS; j++) begin
      r  = {rv, pv[DIV_W-1]};
      pv = {pv[DIV_W-2:0], 1'b0};
      if (r >= (REM_W+1)'(MS_PER_SEC)) begin
        r     = r - (REM_W+1)'(MS_PER_SEC);
        pv[0] = 1'b1;
      end
      rv = r[REM_W-1:0];
    end
    p_step   = pv;
    rem_step = rv;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rate_d  = rate_q;
    burst_d = burst_q;
    tok_d   = tok_q;
    dt_d    = dt_q;
    acc_d   = acc_q;
    p_d     = p_q;
    rem_d   = rem_q;
    sat_d   = sat_q;
    done_d  = 1'b0;
    out_d   = out_q;
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          rate_d  = rate_i;
          burst_d = burst_i;
          tok_d   = tokens_i;
          dt_d    = now_i - last_i;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = R_MUL;
        end
      end
      R_MUL: begin
        acc_d = acc_sum;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(MUL_STEPS - 1)) begin
          sat_d   = |acc_sum[ACC_W-1:SAT_BIT];
          p_d     = DIV_W'(acc_sum[SAT_BIT-1:0]);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = R_DIV;
        end
      end
      R_DIV: begin
        p_d   = p_step;
        rem_d = rem_step;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(DIV_STEPS - 1)) begin
          state_d = R_FIN;
        end
      end
      R_FIN: begin
        if (sat_q || fin_sum >= (QUO_W+1)'(burst_q)) begin
          out_d = burst_q;
        end else begin
          out_d = fin_sum[BURST_W-1:0];
        end
        done_d  = 1'b1;
        state_d = R_IDLE;
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q  <= rate_d;
    burst_q <= burst_d;
    tok_q   <= tok_d;
    dt_q    <= dt_d;
    acc_q   <= acc_d;
    p_q     <= p_d;
    rem_q   <= rem_d;
    sat_q   <= sat_d;
    out_q   <= out_d;
  end

  assign done_o   = done_q;
  assign tokens_o = out_q;

endmodule

// File: sv/two_level_token_bucket_policer_unit.sv
// Two-level token bucket policer, top level. One word is handled at a time. A packet
// meets the network bucket, then the peer bucket, and is refilled against each live
// one that it meets. A refill sweep walks all NETWORKS + PEER_SLOTS entries, refills
// each live one and then takes the output step. The work on each bucket is paced by
// the shared refill unit (40x16 multiply in 16-bit chunks, radix-16 divide by 1000)
// and by the registered read of each bucket table. A new word is taken while the
// previous result still waits on the output register. The output step stalls only
// while that register is still full.
module two_level_token_bucket_policer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tlbp_pkg::MULT_W-1:0]       cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_ms, network_index, peer_index, packet_bytes, rate_bytes_per_sec, burst_bytes
  input  logic [tlbp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind
  input  logic [tlbp_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // drop_count
  output logic [tlbp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // allowed, outcome
  output logic [tlbp_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import tlbp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_REF  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  kind_e                kind_q, kind_d;
  logic [TIME_W-1:0]    now_q, now_d;
  logic [NIDX_W-1:0]    ni_q, ni_d;
  logic [PIDX_W-1:0]    pi_q, pi_d;
  logic [BYTES_W-1:0]   bytes_q, bytes_d;
  logic [RATE_W-1:0]    rate_q, rate_d;
  logic [BURST_W-1:0]   burst_q, burst_d;
  logic                 tbl_q, tbl_d;
  logic [SLOT_AW-1:0]   addr_q, addr_d;
  logic [MULT_W-1:0]    mult_q;
  bucket_t              ent_q, ent_d;
  logic [NETWORKS-1:0]  net_en_q, net_en_d;
  logic [PEER_SLOTS-1:0] peer_en_q, peer_en_d;

  logic                 res_allowed_q, res_allowed_d;
  outcome_e             res_outc_q, res_outc_d;
  logic [DROP_W-1:0]    res_drops_q, res_drops_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_allowed_q, out_allowed_d;
  outcome_e             out_outc_q, out_outc_d;
  logic [DROP_W-1:0]    out_drops_q, out_drops_d;

  logic                 we;
  bucket_t              wdata;
  logic [BUCKET_W-1:0]  net_rdata, peer_rdata;
  bucket_t              rd_ent;
  logic                 ref_start, ref_done;
  logic [BURST_W-1:0]   ref_tokens;

  logic                 en_sel, in_range, last_entry;
  logic [BURST_W-1:0]   mul_burst, load_burst;
  logic [DROP_W-1:0]    drops_inc;
  logic                 accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign rd_ent   = tbl_q ? bucket_t'(peer_rdata) : bucket_t'(net_rdata);
  assign en_sel   = tbl_q ? peer_en_q[addr_q[PEER_AW-1:0]] : net_en_q[addr_q[NET_AW-1:0]];
  assign mul_burst  = BURST_W'(rate_q) * BURST_W'(mult_q);
  assign load_burst = (burst_q != '0) ? burst_q : mul_burst;
  assign drops_inc  = (ent_q.drops == '1) ? ent_q.drops : ent_q.drops + DROP_W'(1);
  assign last_entry = tbl_q ? ({1'b0, addr_q} == (SLOT_AW+1)'(PEER_SLOTS - 1))
                            : ({1'b0, addr_q} == (SLOT_AW+1)'(NETWORKS - 1));

  always_comb begin
    if (kind_q == KIND_SWEEP) begin
      in_range = 1'b1;
    end else if (tbl_q) begin
      in_range = (32'(pi_q) < PEER_SLOTS);
    end else begin
      in_range = (32'(ni_q) < NETWORKS);
    end
  end

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    now_d         = now_q;
    ni_d          = ni_q;
    pi_d          = pi_q;
    bytes_d       = bytes_q;
    rate_d        = rate_q;
    burst_d       = burst_q;
    tbl_d         = tbl_q;
    addr_d        = addr_q;
    ent_d         = ent_q;
    net_en_d      = net_en_q;
    peer_en_d     = peer_en_q;
    res_allowed_d = res_allowed_q;
    res_outc_d    = res_outc_q;
    res_drops_d   = res_drops_q;
    we            = 1'b0;
    wdata         = ent_q;
    ref_start     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d        = kind_e'(s_axis_tuser);
          now_d         = s_axis_tdata[47:0];
          ni_d          = s_axis_tdata[51:48];
          pi_d          = s_axis_tdata[59:52];
          bytes_d       = s_axis_tdata[75:60];
          rate_d        = s_axis_tdata[115:76];
          burst_d       = s_axis_tdata[163:116];
          res_allowed_d = 1'b0;
          res_drops_d   = '0;
          res_outc_d    = OUTC_PASS;
          state_d       = ST_RD;
          case (kind_e'(s_axis_tuser))
            KIND_SET_PEER: begin
              tbl_d  = 1'b1;
              addr_d = SLOT_AW'(s_axis_tdata[59:52]);
            end
            KIND_SWEEP: begin
              tbl_d  = 1'b0;
              addr_d = '0;
            end
            default: begin
              tbl_d  = 1'b0;
              addr_d = SLOT_AW'(s_axis_tdata[51:48]);
            end
          endcase
        end
      end

      ST_RD: state_d = ST_CHK;

      ST_CHK: begin
        ent_d = rd_ent;
        case (kind_q)
          KIND_PACKET: begin
            if (in_range && en_sel && (!tbl_q || rd_ent.tag == ni_q)) begin
              ref_start = 1'b1;
              state_d   = ST_REF;
            end else if (!tbl_q) begin
              tbl_d   = 1'b1;
              addr_d  = SLOT_AW'(pi_q);
              state_d = ST_RD;
            end else begin
              res_allowed_d = 1'b1;
              res_outc_d    = OUTC_PASS;
              state_d       = ST_OUT;
            end
          end
          KIND_SET_NET, KIND_SET_PEER: begin
            if (rate_q == '0 || !in_range) begin
              res_outc_d = OUTC_SET_REJ;
            end else begin
              we            = 1'b1;
              wdata.tag     = ni_q;
              wdata.rate    = rate_q;
              wdata.burst   = load_burst;
              wdata.tokens  = load_burst;
              wdata.last_ms = now_q;
              wdata.drops   = en_sel ? rd_ent.drops : '0;
              if (tbl_q) begin
                peer_en_d[addr_q[PEER_AW-1:0]] = 1'b1;
              end else begin
                net_en_d[addr_q[NET_AW-1:0]] = 1'b1;
              end
              res_outc_d = OUTC_SET_OK;
            end
            state_d = ST_OUT;
          end
          default: begin
            if (en_sel) begin
              ref_start = 1'b1;
              state_d   = ST_REF;
            end else if (last_entry) begin
              if (tbl_q) begin
                res_outc_d = OUTC_SWEPT;
                state_d    = ST_OUT;
              end else begin
                tbl_d   = 1'b1;
                addr_d  = '0;
                state_d = ST_RD;
              end
            end else begin
              addr_d  = addr_q + SLOT_AW'(1);
              state_d = ST_RD;
            end
          end
        endcase
      end

      ST_REF: begin
        if (ref_done) begin
          state_d = ST_UPD;
        end
      end

      ST_UPD: begin
        we            = 1'b1;
        wdata.last_ms = now_q;
        if (kind_q == KIND_PACKET) begin
          if (ref_tokens < BURST_W'(bytes_q)) begin
            wdata.tokens  = ref_tokens;
            wdata.drops   = drops_inc;
            res_allowed_d = 1'b0;
            res_outc_d    = tbl_q ? OUTC_PEER_DROP : OUTC_NET_DROP;
            res_drops_d   = drops_inc;
            state_d       = ST_OUT;
          end else begin
            wdata.tokens = ref_tokens - BURST_W'(bytes_q);
            if (!tbl_q) begin
              tbl_d   = 1'b1;
              addr_d  = SLOT_AW'(pi_q);
              state_d = ST_RD;
            end else begin
              res_allowed_d = 1'b1;
              res_outc_d    = OUTC_PASS;
              state_d       = ST_OUT;
            end
          end
        end else begin
          wdata.tokens = ref_tokens;
          if (last_entry) begin
            if (tbl_q) begin
              res_outc_d = OUTC_SWEPT;
              state_d    = ST_OUT;
            end else begin
              tbl_d   = 1'b1;
              addr_d  = '0;
              state_d = ST_RD;
            end
          end else begin
            addr_d  = addr_q + SLOT_AW'(1);
            state_d = ST_RD;
          end
        end
      end

      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    out_allowed_d = out_allowed_q;
    out_outc_d    = out_outc_q;
    out_drops_d   = out_drops_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      out_valid_d   = 1'b1;
      out_allowed_d = res_allowed_q;
      out_outc_d    = res_outc_q;
      out_drops_d   = res_drops_q;
    end
  end

  tlbp_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (NETWORKS)
  ) u_net_ram (
    .clk_i   (clk_i),
    .we_i    (we && !tbl_q),
    .waddr_i (addr_q[NET_AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (addr_q[NET_AW-1:0]),
    .rdata_o (net_rdata)
  );

  tlbp_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (PEER_SLOTS)
  ) u_peer_ram (
    .clk_i   (clk_i),
    .we_i    (we && tbl_q),
    .waddr_i (addr_q[PEER_AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (addr_q[PEER_AW-1:0]),
    .rdata_o (peer_rdata)
  );

  tlbp_refill u_refill (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ref_start),
    .rate_i   (rd_ent.rate),
    .burst_i  (rd_ent.burst),
    .tokens_i (rd_ent.tokens),
    .last_i   (rd_ent.last_ms),
    .now_i    (now_q),
    .done_o   (ref_done),
    .tokens_o (ref_tokens)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mult_q      <= MULT_RESET;
      net_en_q    <= '0;
      peer_en_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        mult_q <= cfg_wdata_i;
      end
      net_en_q    <= net_en_d;
      peer_en_q   <= peer_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    now_q         <= now_d;
    ni_q          <= ni_d;
    pi_q          <= pi_d;
    bytes_q       <= bytes_d;
    rate_q        <= rate_d;
    burst_q       <= burst_d;
    tbl_q         <= tbl_d;
    addr_q        <= addr_d;
    ent_q         <= ent_d;
    res_allowed_q <= res_allowed_d;
    res_outc_q    <= res_outc_d;
    res_drops_q   <= res_drops_d;
    out_allowed_q <= out_allowed_d;
    out_outc_q    <= out_outc_d;
    out_drops_q   <= out_drops_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_drops_q;
  assign m_axis_tuser  = {out_outc_q, out_allowed_q};

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RD)
    else $error("accepted word did not start a table read");

  a_refill_only_from_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_start |-> state_q == ST_CHK)
    else $error("refill started outside the check step");

  a_upd_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> $past(ref_done))
    else $error("bucket update without a finished refill");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result word raised outside the output step");

endmodule
